// ----- hw/rtl/ddi_pkg.sv -----
package ddi_pkg;

   // widths of the request and response fields
   localparam int NUMBER_WIDTH = 64;
   localparam int INDEX_WIDTH  = 16;
   localparam int DIGIT_WIDTH  = 5;
   localparam int BCD_DIGIT_W  = 4;

   // most decimal digits that a 64-bit magnitude can have
   localparam int MAX_DIGIT_SLOTS = 20;

   // digit code returned when the index lies beyond the digit count
   localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = 5'h1F;

   // bcd digits of five and above are pre-corrected by three before doubling
   localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_ADD   = 4'd3;

endpackage

// ----- hw/rtl/ddi_cell.sv -----
module ddi_cell
   import ddi_pkg::*;
#(
   parameter int NDIG = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      prev_valid,
   input  logic [4*NDIG-1:0]         prev_bcd,
   input  logic [NUMBER_WIDTH-1:0]   prev_bin,
   input  logic [INDEX_WIDTH-1:0]    prev_index,
   output logic                      next_valid,
   output logic [4*NDIG-1:0]         next_bcd,
   output logic [NUMBER_WIDTH-1:0]   next_bin,
   output logic [INDEX_WIDTH-1:0]    next_index
);

   localparam int BCD_W = 4 * NDIG;

   logic                    valid_ff;
   logic [BCD_W-1:0]        bcd_ff, bcd_in, bcd_adj;
   logic [NUMBER_WIDTH-1:0] bin_ff, bin_in;
   logic [INDEX_WIDTH-1:0]  index_ff;

   // add-three correction on every digit of five or more, then double and take in the next bit
   always_comb begin
      bcd_adj = prev_bcd;
      for (int i = 0; i < NDIG; i++) begin
         if (prev_bcd[i*BCD_DIGIT_W +: BCD_DIGIT_W] >= BCD_ADJ_LIMIT) begin
            bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] =
               prev_bcd[i*BCD_DIGIT_W +: BCD_DIGIT_W] + BCD_ADJ_ADD;
         end
      end
      // top carry drops out: the value is kept modulo ten to the digit count
      bcd_in = {bcd_adj[BCD_W-2:0], prev_bin[NUMBER_WIDTH-1]};
      bin_in = {prev_bin[NUMBER_WIDTH-2:0], 1'b0};
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= prev_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (enable) begin
         bcd_ff   <= bcd_in;
         bin_ff   <= bin_in;
         index_ff <= prev_index;
      end
   end

   assign next_valid = valid_ff;
   assign next_bcd   = bcd_ff;
   assign next_bin   = bin_ff;
   assign next_index = index_ff;

endmodule

// ----- hw/rtl/ddi_select.sv -----
module ddi_select
   import ddi_pkg::*;
#(
   parameter int NDIG = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          conv_valid,
   input  logic [4*NDIG-1:0]             conv_bcd,
   input  logic [INDEX_WIDTH-1:0]        conv_index,
   output logic                          rsp_valid,
   output logic signed [DIGIT_WIDTH-1:0] rsp_digit
);

   localparam int CW = $clog2(NDIG + 1);
   localparam int PW = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic [BCD_DIGIT_W-1:0]  digits [NDIG];
   logic [CW-1:0]           count;
   logic [CW-1:0]           pos;
   logic [DIGIT_WIDTH-1:0]  digit_in;
   logic                    valid_ff;
   logic [DIGIT_WIDTH-1:0]  digit_ff;

   // split the bcd word into digits, least significant first
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         digits[i] = conv_bcd[i*BCD_DIGIT_W +: BCD_DIGIT_W];
      end
   end

   // digit count: position of the highest non-zero digit, at least one
   always_comb begin
      count = CW'(1);
      for (int i = 0; i < NDIG; i++) begin
         if (digits[i] != '0) begin
            count = CW'(i + 1);
         end
      end
   end

   // pick the digit counted from the most significant end
   always_comb begin
      pos = count - CW'(1) - conv_index[CW-1:0];
      if (conv_index >= INDEX_WIDTH'(count)) begin
         digit_in = NO_DIGIT;
      end else begin
         digit_in = {1'b0, digits[pos[PW-1:0]]};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= conv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         digit_ff <= digit_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_digit = digit_ff;

endmodule

// ----- hw/rtl/decimal_digit_at_index.sv -----
// decimal_digit_at_index
//
// A request carries a signed 64-bit number and a 16-bit digit index on the
// req_ channel (valid/ready). The response on the rsp_ channel is the decimal
// digit of the number's magnitude at that index, counted from the most
// significant digit at index 0, or -1 when the index is at or beyond the
// digit count. Zero has the single digit 0; the most negative value is taken
// as its unsigned magnitude.
// The number passes an entry stage that forms the magnitude, then a row of
// 64 double-dabble cells, one per magnitude bit, then an output register that
// counts the digits and selects one. One request is taken every cycle unless
// the output stalls, set by the one-bit-per-cell conversion row. The row holds
// MAX_DIGITS bcd digits, limited to one up to 20; below 20 only the low MAX_DIGITS
// digits of the magnitude are kept.
// While rsp_valid is high and rsp_ready is low the whole pipeline holds and
// req_ready is low; it moves again as soon as the response is taken.
// Reset clears all valid flags; no response is pending after reset.
module decimal_digit_at_index
   import ddi_pkg::*;
#(
   parameter int MAX_DIGITS = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [NUMBER_WIDTH-1:0] req_number,
   input  logic [INDEX_WIDTH-1:0]        req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DIGIT_WIDTH-1:0] rsp_digit
);

   // digit positions held by the row, limited to one up to the full width
   localparam int HELD_DIGITS = (MAX_DIGITS < 1) ? 1 :
                                ((MAX_DIGITS > MAX_DIGIT_SLOTS) ? MAX_DIGIT_SLOTS
                                                                : MAX_DIGITS);
   localparam int BCD_W = 4 * HELD_DIGITS;

   logic                    enable;
   logic                    entry_valid_ff;
   logic [NUMBER_WIDTH-1:0] mag_ff, mag_in;
   logic [INDEX_WIDTH-1:0]  entry_index_ff;

   logic                    chain_valid [NUMBER_WIDTH+1];
   logic [BCD_W-1:0]        chain_bcd   [NUMBER_WIDTH+1];
   logic [NUMBER_WIDTH-1:0] chain_bin   [NUMBER_WIDTH+1];
   logic [INDEX_WIDTH-1:0]  chain_index [NUMBER_WIDTH+1];

   // the pipeline advances whenever the output register is free or drained
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // entry stage: magnitude of the number
   assign mag_in = req_number[NUMBER_WIDTH-1] ? (~req_number + NUMBER_WIDTH'(1))
                                              : req_number;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (enable) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff         <= mag_in;
         entry_index_ff <= req_index;
      end
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_bcd[0]   = '0;
   assign chain_bin[0]   = mag_ff;
   assign chain_index[0] = entry_index_ff;

   // conversion row: one cell per magnitude bit, most significant first
   for (genvar g = 0; g < NUMBER_WIDTH; g++) begin : g_cell
      ddi_cell #(
         .NDIG (HELD_DIGITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .prev_valid (chain_valid[g]),
         .prev_bcd   (chain_bcd[g]),
         .prev_bin   (chain_bin[g]),
         .prev_index (chain_index[g]),
         .next_valid (chain_valid[g+1]),
         .next_bcd   (chain_bcd[g+1]),
         .next_bin   (chain_bin[g+1]),
         .next_index (chain_index[g+1])
      );
   end

   // digit count, index check and output register
   ddi_select #(
      .NDIG (HELD_DIGITS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .conv_valid (chain_valid[NUMBER_WIDTH]),
      .conv_bcd   (chain_bcd[NUMBER_WIDTH]),
      .conv_index (chain_index[NUMBER_WIDTH]),
      .rsp_valid  (rsp_valid),
      .rsp_digit  (rsp_digit)
   );

endmodule

// ----- tb/decimal_digit_at_index_test.sv -----
`timescale 1ns / 1ps

module decimal_digit_at_index_test
   import ddi_pkg::*;
();

   localparam int CONVERTER_DIGITS = 19;
   localparam int DIGIT_SLOTS      = 20;
   localparam int RANDOM_REQUESTS  = 400;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES     = 80;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DIRECTED_COUNT   = 23;

   // one directed request, with a typed-in digit where it is obvious
   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic [INDEX_WIDTH-1:0]  index;
      logic                    fixed;
      logic [DIGIT_WIDTH-1:0]  digit;
   } directed_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [NUMBER_WIDTH-1:0] req_number = '0;
   logic [INDEX_WIDTH-1:0]         req_index = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [DIGIT_WIDTH-1:0]  rsp_digit;

   logic [DIGIT_WIDTH-1:0] pending_digits [$];
   directed_row_type       directed_rows [0:DIRECTED_COUNT-1];
   int                     failures = 0;
   int                     cycles = 0;
   bit                     idling = 1'b1;
   bit                     long_hold = 1'b0;

   decimal_digit_at_index #(
      .MAX_DIGITS(CONVERTER_DIGITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_number(req_number),
      .req_index (req_index),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_digit (rsp_digit)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decimal digit of the magnitude at the index, most significant first
   function automatic logic [DIGIT_WIDTH-1:0] digit_at(input logic [NUMBER_WIDTH-1:0] number,
                                                       input logic [INDEX_WIDTH-1:0] index);
      logic [NUMBER_WIDTH-1:0] magnitude;
      logic [3:0]              digits [DIGIT_SLOTS];
      int                      held;
      int                      count;
      held = CONVERTER_DIGITS;
      if (held < 1) held = 1;
      if (held > DIGIT_SLOTS) held = DIGIT_SLOTS;
      magnitude = number[NUMBER_WIDTH-1] ? ~number + 1'b1 : number;
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         digits[i] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
      end
      // leading zeros dropped, at least one digit
      count = 1;
      for (int i = 0; i < held; i++) begin
         if (digits[i] != 4'd0) count = i + 1;
      end
      if (int'(index) >= count) return NO_DIGIT;
      return {1'b0, digits[count - 1 - int'(index)]};
   endfunction

   // offer one request, after a random gap when idling, and hold it until taken
   task automatic send_request(input logic [NUMBER_WIDTH-1:0] number,
                               input logic [INDEX_WIDTH-1:0] index,
                               input logic [DIGIT_WIDTH-1:0] expected);
      int gap;
      gap = idling ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= number;
      req_index  <= index;
      do @(posedge clock); while (!req_ready);
      pending_digits.push_back(expected);
   endtask

   // generous run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[decimal_digit_at_index] ERROR");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off, and checking
   initial begin
      int                     stall;
      logic [DIGIT_WIDTH-1:0] expected;
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         stall = idling ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_digits.size() == 0) begin
            if (failures < 10)
               $display("unexpected response: digit %0d with no request outstanding",
                        rsp_digit);
            failures++;
         end else begin
            expected = pending_digits.pop_front();
            if (rsp_digit !== expected) begin
               if (failures < 10)
                  $display("digit mismatch: expected %0d (%h), got %0d (%h)",
                           $signed(expected), expected, rsp_digit, rsp_digit);
               failures++;
            end
         end
      end
   end

   // request side: directed table, then random numbers
   initial begin
      logic [NUMBER_WIDTH-1:0] number;
      logic [INDEX_WIDTH-1:0]  index;
      logic [DIGIT_WIDTH-1:0]  expected;
      int                      kind;

      directed_rows = '{
         // zero has the single digit 0
         '{64'd0, 16'd0, 1'b1, 5'd0},
         '{64'd0, 16'd1, 1'b1, NO_DIGIT},
         '{64'd0, 16'hFFFF, 1'b1, NO_DIGIT},
         // most negative value reads as its unsigned magnitude
         '{64'h8000_0000_0000_0000, 16'd0, 1'b1, 5'd9},
         '{64'h8000_0000_0000_0000, 16'd18, 1'b1, 5'd8},
         '{64'h8000_0000_0000_0000, 16'd19, 1'b1, NO_DIGIT},
         // largest positive value
         '{64'h7FFF_FFFF_FFFF_FFFF, 16'd0, 1'b1, 5'd9},
         '{64'h7FFF_FFFF_FFFF_FFFF, 16'd18, 1'b1, 5'd7},
         '{64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, NO_DIGIT},
         // single digits and ten, sign dropped
         '{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b1, 5'd1},
         '{64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 1'b1, NO_DIGIT},
         '{64'd1, 16'd0, 1'b1, 5'd1},
         '{64'd9, 16'd0, 1'b1, 5'd9},
         '{-64'sd9, 16'd0, 1'b1, 5'd9},
         '{64'd10, 16'd1, 1'b1, 5'd0},
         // powers of ten and runs of nines
         '{64'd1000000000000000000, 16'd0, 1'b1, 5'd1},
         '{64'd1000000000000000000, 16'd18, 1'b1, 5'd0},
         '{-64'sd1000000000000000000, 16'd19, 1'b1, NO_DIGIT},
         '{64'd999999999999999999, 16'd17, 1'b0, 5'd0},
         // mixed patterns, checked by the predictor
         '{-64'sd1234567890, 16'd4, 1'b0, 5'd0},
         '{64'h5555_5555_5555_5555, 16'd3, 1'b0, 5'd0},
         '{64'hAAAA_AAAA_AAAA_AAAA, 16'd7, 1'b0, 5'd0},
         '{64'd12345, 16'hAAAA, 1'b0, 5'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         expected = directed_rows[r].fixed ? directed_rows[r].digit
                                           : digit_at(directed_rows[r].number,
                                                      directed_rows[r].index);
         send_request(directed_rows[r].number, directed_rows[r].index, expected);
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         // stretches with no idling on either side
         idling = !((n >= 100 && n < 140) || (n >= 250 && n < 280));
         if (n == 150) long_hold = 1'b1;
         // pause until the pipeline is empty
         if (n == 300) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_digits.size() != 0) @(posedge clock);
         end

         kind = $urandom_range(0, 4);
         case (kind)
            0: number = {$urandom, $urandom};
            1: begin
               number = {$urandom, $urandom} >> $urandom_range(0, 63);
               if ($urandom_range(0, 1)) number = -number;
            end
            2: begin
               number = 64'd1;
               repeat ($urandom_range(0, 18)) number = number * 10;
               number = number + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1)) number = -number;
            end
            3: begin
               // decimal digits with plenty of zeros among them
               number = 64'd0;
               repeat ($urandom_range(1, 19))
                  number = number * 10 + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9));
               if ($urandom_range(0, 1)) number = -number;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: number = 64'd0;
                  1: number = 64'h8000_0000_0000_0000;
                  2: number = 64'h7FFF_FFFF_FFFF_FFFF;
                  default: number = 64'hFFFF_FFFF_FFFF_FFFF;
               endcase
            end
         endcase

         // mostly indexes near the digit count, some across the full range
         if ($urandom_range(0, 9) == 0) index = 16'($urandom_range(0, 16'hFFFF));
         else index = 16'($urandom_range(0, 21));

         send_request(number, index, digit_at(number, index));
      end
      req_valid <= 1'b0;

      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      failures += pending_digits.size();

      if (failures == 0) begin
         $display("[decimal_digit_at_index] OK");
      end else begin
         $display("[decimal_digit_at_index] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ddi_pkg.sv
hw/rtl/ddi_cell.sv
hw/rtl/ddi_select.sv
hw/rtl/decimal_digit_at_index.sv
tb/decimal_digit_at_index_test.sv
